FILE: rtl/chacha20_stream_cipher_macros.svh
// Assertion helpers, clocked on clk, off while rst_n is low.
`ifndef CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication.
`define CC20_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define CC20_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/cc20_pkg.sv
package cc20_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int NUM_WORDS         = 16;

  typedef logic [31:0] word_t;
  typedef word_t [NUM_WORDS-1:0] block_t;

  localparam word_t SIGMA_0 = 32'h61707865;
  localparam word_t SIGMA_1 = 32'h3320646e;
  localparam word_t SIGMA_2 = 32'h79622d32;
  localparam word_t SIGMA_3 = 32'h6b206574;

  // config register indexes; REG_SPARE has no register behind it
  typedef enum logic [2:0] {
    REG_KEY_0,
    REG_KEY_1,
    REG_KEY_2,
    REG_KEY_3,
    REG_NONCE_LO,
    REG_NONCE_HI,
    REG_START_CNT,
    REG_SPARE
  } reg_idx_t;

  // Quarter-round steps: a+=b, d^=a, d<<<16 / c+=d, b^=c, b<<<12 / ... 8 / ... 7
  typedef enum logic [1:0] {
    QS_A16,
    QS_C12,
    QS_A8,
    QS_C7
  } qstep_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

FILE: rtl/cc20_qstep.sv
module cc20_qstep (
  input  cc20_pkg::word_t  p,
  input  cc20_pkg::word_t  q,
  input  cc20_pkg::word_t  r,
  input  cc20_pkg::qstep_t step,
  output cc20_pkg::word_t  sum,
  output cc20_pkg::word_t  mix
);

  cc20_pkg::word_t t;

  assign sum = p + q;
  assign t   = r ^ sum;

  always_comb begin
    unique case (step)
      cc20_pkg::QS_A16: mix = {t[15:0], t[31:16]};
      cc20_pkg::QS_C12: mix = {t[19:0], t[31:20]};
      cc20_pkg::QS_A8:  mix = {t[23:0], t[31:24]};
      cc20_pkg::QS_C7:  mix = {t[24:0], t[31:25]};
      default:          mix = t;
    endcase
  end

endmodule

FILE: rtl/cc20_core.sv
module cc20_core #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  cc20_pkg::block_t     init_words,
  input  logic [3:0]           rd_idx,
  output cc20_pkg::word_t      rd_word,
  output cc20_pkg::core_stat_t stat
);

  localparam int RW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_FF
  } cstate_t;

  cstate_t          state_r, state_nxt;
  cc20_pkg::block_t x_r, x_nxt;
  cc20_pkg::qstep_t step_r, step_nxt;
  logic [1:0]       col_r, col_nxt;
  logic             diag_r, diag_nxt;
  logic [RW-1:0]    dr_r, dr_nxt;
  logic [3:0]       ff_r, ff_nxt;
  logic             done_r, done_nxt;

  cc20_pkg::word_t  p, q, r, sum, mix;
  cc20_pkg::block_t y, z;
  logic             last_qr, end_col, end_diag;

  cc20_qstep u_qstep (
    .p    (p),
    .q    (q),
    .r    (r),
    .step (step_r),
    .sum  (sum),
    .mix  (mix)
  );

  // round operands sit at column 0 of each row: words 0, 4, 8, 12; feed-forward adds init_words[ff_r] to word 0
  always_comb begin
    if (state_r == C_FF) begin
      p = x_r[0];
      q = init_words[ff_r];
      r = x_r[12];
    end else if (step_r == cc20_pkg::QS_A16 || step_r == cc20_pkg::QS_A8) begin
      p = x_r[0];
      q = x_r[4];
      r = x_r[12];
    end else begin
      p = x_r[8];
      q = x_r[12];
      r = x_r[4];
    end
  end

  assign last_qr  = (step_r == cc20_pkg::QS_C7) && (col_r == 2'd3);
  assign end_col  = last_qr && !diag_r;
  assign end_diag = last_qr && diag_r;

  // write back, then rotate rows; end of a round also (un)diagonalizes
  always_comb begin
    logic [1:0] amt;
    y = x_r;
    if (step_r == cc20_pkg::QS_A16 || step_r == cc20_pkg::QS_A8) begin
      y[0]  = sum;
      y[12] = mix;
    end else begin
      y[8]  = sum;
      y[4]  = mix;
    end
    for (int rr = 0; rr < 4; rr++) begin
      amt = 2'd1 + (end_col ? 2'(rr) : (end_diag ? 2'(4 - rr) : 2'd0));
      for (int j = 0; j < 4; j++) begin
        z[{2'(rr), 2'(j)}] = y[{2'(rr), 2'(2'(j) + amt)}];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    step_nxt  = step_r;
    col_nxt   = col_r;
    diag_nxt  = diag_r;
    dr_nxt    = dr_r;
    ff_nxt    = ff_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          x_nxt     = init_words;
          step_nxt  = cc20_pkg::QS_A16;
          col_nxt   = 2'd0;
          diag_nxt  = 1'b0;
          dr_nxt    = '0;
          state_nxt = C_ROUND;
        end
      end
      C_ROUND: begin
        step_nxt = cc20_pkg::qstep_t'(step_r + 2'd1);
        if (step_r == cc20_pkg::QS_C7) begin
          x_nxt   = z;
          col_nxt = col_r + 2'd1;
          if (col_r == 2'd3) begin
            diag_nxt = !diag_r;
            if (diag_r) begin
              if (dr_r == RW'(DOUBLE_ROUNDS - 1)) begin
                ff_nxt    = 4'd0;
                state_nxt = C_FF;
              end else begin
                dr_nxt = dr_r + RW'(1);
              end
            end
          end
        end else begin
          x_nxt = y;
        end
      end
      C_FF: begin
        for (int i = 0; i < cc20_pkg::NUM_WORDS - 1; i++) begin
          x_nxt[i] = x_r[i+1];
        end
        x_nxt[cc20_pkg::NUM_WORDS-1] = sum;
        ff_nxt = ff_r + 4'd1;
        if (ff_r == 4'd15) begin
          done_nxt  = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      step_r  <= cc20_pkg::QS_A16;
      col_r   <= 2'd0;
      diag_r  <= 1'b0;
      dr_r    <= '0;
      ff_r    <= 4'd0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      col_r   <= col_nxt;
      diag_r  <= diag_nxt;
      dr_r    <= dr_nxt;
      ff_r    <= ff_nxt;
      done_r  <= done_nxt;
    end
    x_r <= x_nxt;
  end

  assign rd_word   = x_r[rd_idx];
  assign stat.busy = (state_r != C_IDLE);
  assign stat.done = done_r;

endmodule

FILE: rtl/chacha20_stream_cipher.sv
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    in_data_byte[7:0], in_end_of_message
// out      out  out_valid / out_stall  out_byte[7:0], out_next_counter[31:0]
// cfg      in   cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[63:0]
//
// A byte with keystream on hand: accepted into data_r, then XORed and registered in out_byte_r from S_EMIT.
// A byte that starts a block first waits in S_GEN while the core makes the block: one
// quarter-round step per cycle, then one feed-forward add per cycle, on the shared unit.
// rst_n is synchronous, active low; key, nonce, counter, byte position and ready flag clear.
// A new byte is taken while the previous result waits under out_stall; the result
// register holds until the beat completes.
`include "chacha20_stream_cipher_macros.svh"

module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [31:0] out_next_counter,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GEN,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [3:0][63:0]    key_r, key_nxt;
  logic [63:0]         nonce_lo_r, nonce_lo_nxt;
  logic [31:0]         nonce_hi_r, nonce_hi_nxt;
  logic [31:0]         count_r, count_nxt;
  logic [5:0]          pos_r, pos_nxt;
  logic                ready_r, ready_nxt;
  logic [7:0]          data_r, data_nxt;
  logic                last_r, last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic [31:0]         out_cnt_r, out_cnt_nxt;

  cc20_pkg::block_t     init_words;
  cc20_pkg::word_t      ks_word;
  cc20_pkg::core_stat_t core_stat;
  logic                 core_start;
  logic [7:0]           ks_byte;
  logic [5:0]           pos_inc;

  always_comb begin
    init_words[0]  = cc20_pkg::SIGMA_0;
    init_words[1]  = cc20_pkg::SIGMA_1;
    init_words[2]  = cc20_pkg::SIGMA_2;
    init_words[3]  = cc20_pkg::SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      init_words[4 + 2*k] = key_r[k][31:0];
      init_words[5 + 2*k] = key_r[k][63:32];
    end
    init_words[12] = count_r;
    init_words[13] = nonce_lo_r[31:0];
    init_words[14] = nonce_lo_r[63:32];
    init_words[15] = nonce_hi_r;
  end

  cc20_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (core_start),
    .init_words (init_words),
    .rd_idx     (pos_r[5:2]),
    .rd_word    (ks_word),
    .stat       (core_stat)
  );

  assign ks_byte = ks_word[{pos_r[1:0], 3'b000} +: 8];
  assign pos_inc = pos_r + 6'd1;

  assign in_stall   = (state_r != S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign core_start = (state_r == S_IDLE) && in_valid && !ready_r;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    nonce_lo_nxt  = nonce_lo_r;
    nonce_hi_nxt  = nonce_hi_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    ready_nxt     = ready_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_cnt_nxt   = out_cnt_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cc20_pkg::REG_KEY_0:     key_nxt[0]   = cfg_data;
        cc20_pkg::REG_KEY_1:     key_nxt[1]   = cfg_data;
        cc20_pkg::REG_KEY_2:     key_nxt[2]   = cfg_data;
        cc20_pkg::REG_KEY_3:     key_nxt[3]   = cfg_data;
        cc20_pkg::REG_NONCE_LO:  nonce_lo_nxt = cfg_data;
        cc20_pkg::REG_NONCE_HI:  nonce_hi_nxt = cfg_data[31:0];
        cc20_pkg::REG_START_CNT: count_nxt    = cfg_data[31:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          data_nxt  = in_data_byte;
          last_nxt  = in_end_of_message;
          state_nxt = ready_r ? S_EMIT : S_GEN;
        end
      end
      S_GEN: begin
        if (core_stat.done) begin
          ready_nxt = 1'b1;
          count_nxt = count_r + 32'd1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_r ^ ks_byte;
          out_cnt_nxt   = count_r;
          if (pos_inc == 6'd0 || last_r) begin
            pos_nxt   = 6'd0;
            ready_nxt = 1'b0;
          end else begin
            pos_nxt = pos_inc;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_r       <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_r       <= key_nxt;
      nonce_lo_r  <= nonce_lo_nxt;
      nonce_hi_r  <= nonce_hi_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
    data_r     <= data_nxt;
    last_r     <= last_nxt;
    out_byte_r <= out_byte_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_next_counter = out_cnt_r;

  `CC20_ASSERT_NEXT(a_accept_stalls, in_valid && !in_stall, in_stall)
  `CC20_ASSERT_IMPL(a_done_in_gen, core_stat.done, state_r == S_GEN)
  `CC20_ASSERT_NEXT(a_done_sets_ready, core_stat.done, ready_r)
  `CC20_ASSERT_IMPL(a_gen_core_busy, state_r == S_GEN && !core_stat.done, core_stat.busy)

endmodule
